[hw/rtl/fdc_pkg.sv]
// ----------------------------------------------------------------------------
// fdc_pkg - shared definitions of the batch flow dispense controller
// Field widths, command and mode codes, register indexes and the command /
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fdc_pkg;

  // pulse counter width of a run
  localparam int COUNT_WIDTH = 20;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // fixed field widths
  localparam int OP_W      = 3;
  localparam int TGT_W     = 20;
  localparam int DELTA_W   = 16;
  localparam int ELAPSED_W = 16;
  localparam int MODE_W    = 3;
  localparam int FAULT_W   = 2;
  localparam int TOTAL_W   = 32;
  localparam int QUIET_W   = 16;

  // configuration register widths
  localparam int LAG_W     = 12;
  localparam int EXTRA_W   = 9;
  localparam int OVER_W    = 12;
  localparam int SMALL_W   = 16;
  localparam int TIMEOUT_W = 16;
  localparam int CAL_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LAG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_EXTRA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_TGT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_FLOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TGT    = 3'd5;

  // command codes
  localparam logic [OP_W-1:0] OP_START     = 3'd0;
  localparam logic [OP_W-1:0] OP_START_CAL = 3'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME    = 3'd4;
  localparam logic [OP_W-1:0] OP_CANCEL    = 3'd5;
  localparam logic [OP_W-1:0] OP_ACK       = 3'd6;

  // run modes
  localparam logic [MODE_W-1:0] M_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] M_RUN     = 3'd1;
  localparam logic [MODE_W-1:0] M_PAUSE   = 3'd2;
  localparam logic [MODE_W-1:0] M_DONE    = 3'd3;
  localparam logic [MODE_W-1:0] M_FAULT   = 3'd4;
  localparam logic [MODE_W-1:0] M_CAL     = 3'd5;
  localparam logic [MODE_W-1:0] M_CALDONE = 3'd6;

  // fault kinds
  localparam logic [FAULT_W-1:0] F_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] F_NO_FLOW = 2'd1;
  localparam logic [FAULT_W-1:0] F_OVER    = 2'd2;

  // early-stop divider: (2*delta*lag + elapsed) / (2*elapsed)
  localparam int DIV_NUM_W = DELTA_W + LAG_W + 2;
  localparam int DIV_DEN_W = ELAPSED_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam int EARLY_W   = (DIV_NUM_W + 1 > COUNT_WIDTH) ? DIV_NUM_W + 1 : COUNT_WIDTH;

  // 40 percent cap = floor(2*t/5), done as a multiply by a rounded-up reciprocal
  localparam int CAP_NUM   = 2;
  localparam int CAP_DEN   = 5;
  localparam int CAP_SHIFT = COUNT_WIDTH + 3;
  localparam logic [COUNT_WIDTH:0] CAP_RECIP =
    (COUNT_WIDTH+1)'(((64'd1 << CAP_SHIFT) + CAP_DEN - 1) / CAP_DEN);

  // stream widths
  localparam int IN_BITS     = TGT_W + DELTA_W + ELAPSED_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = MODE_W + 1 + 2 * COUNT_WIDTH + FAULT_W + TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic [TOTAL_W-1:0]     total_pulses;
    logic [FAULT_W-1:0]     fault_kind;
    logic [COUNT_WIDTH-1:0] stop_threshold;
    logic [COUNT_WIDTH-1:0] pulses_dispensed;
    logic                   pump_on;
    logic [MODE_W-1:0]      run_mode;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic mul;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sample_go;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

[hw/rtl/fdc_div.sv]
// ----------------------------------------------------------------------------
// fdc_div - radix-2 restoring divider
// One quotient bit per cycle; pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module fdc_div
  import fdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;

  // trial subtract of one step
  assign shifted = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

[hw/rtl/fdc_dp.sv]
// ----------------------------------------------------------------------------
// fdc_dp - datapath of the dispense controller
// Configuration registers, run state, early-stop estimate, result register.
// ----------------------------------------------------------------------------
module fdc_dp
  import fdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // incoming item
  input  logic [OP_W-1:0]       in_op,
  input  logic [TGT_W-1:0]      in_target,
  input  logic [DELTA_W-1:0]    in_delta,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  // controller link
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  // result
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_word_t             out_data
);

  // configuration
  logic [LAG_W-1:0]     lag_r;
  logic [EXTRA_W-1:0]   extra_r;
  logic [OVER_W-1:0]    over_r;
  logic [SMALL_W-1:0]   small_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [CAL_W-1:0]     cal_r;

  // run state
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] run_r, run_nxt;
  logic [COUNT_WIDTH-1:0] target_r, target_nxt;
  logic [QUIET_W-1:0]     quiet_r, quiet_nxt;
  logic [FAULT_W-1:0]     fault_r, fault_nxt;
  logic [COUNT_WIDTH-1:0] stop_r, stop_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;

  // latched item and intermediates
  logic [OP_W-1:0]             op_r;
  logic [TGT_W-1:0]            tgt_r;
  logic [DELTA_W-1:0]          delta_r;
  logic [ELAPSED_W-1:0]        elapsed_r;
  logic [DELTA_W+LAG_W-1:0]    prod_r;
  logic [COUNT_WIDTH-1:0]      cap_r;
  logic [COUNT_WIDTH-1:0]      early_r;
  logic [2*COUNT_WIDTH+1:0]    cap_prod;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  // divider
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;

  // sample arithmetic
  logic [COUNT_WIDTH:0]   run_sum;
  logic [COUNT_WIDTH-1:0] run_s;
  logic [QUIET_W:0]       quiet_sum;
  logic [QUIET_W-1:0]     quiet_s;
  logic [COUNT_WIDTH:0]   over_lim;
  logic [COUNT_WIDTH-1:0] stop_at;
  logic [COUNT_WIDTH-1:0] tgt_sat;
  logic [COUNT_WIDTH-1:0] total_src;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_s;
  logic [DIV_NUM_W-1:0]   rate;
  logic [EARLY_W-1:0]     early_sum;
  logic [COUNT_WIDTH-1:0] early_c;
  logic                   run_active;

  localparam int TGT_CMP_W = (TGT_W > COUNT_WIDTH) ? TGT_W : COUNT_WIDTH;

  assign run_active = (mode_r == M_RUN) || (mode_r == M_CAL);

  // status toward the controller
  assign stat.sample_go = (in_op == OP_SAMPLE) && run_active;
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid_r && !out_ready;

  // configuration writes, masked to register widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r     <= LAG_W'(300);
      extra_r   <= EXTRA_W'(20);
      over_r    <= OVER_W'(13);
      small_r   <= SMALL_W'(131);
      timeout_r <= TIMEOUT_W'(6000);
      cal_r     <= CAL_W'(263);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_LAG:   lag_r     <= cfg_wdata[LAG_W-1:0];
        CFG_STOP_EXTRA: extra_r   <= cfg_wdata[EXTRA_W-1:0];
        CFG_OVER_LIMIT: over_r    <= cfg_wdata[OVER_W-1:0];
        CFG_SMALL_TGT:  small_r   <= cfg_wdata[SMALL_W-1:0];
        CFG_NO_FLOW:    timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_CAL_TGT:    cal_r     <= cfg_wdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch, delta*lag product and the 40 percent cap of the target
  assign cap_prod = {target_r, 1'b0} * CAP_RECIP;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r      <= in_op;
      tgt_r     <= in_target;
      delta_r   <= in_delta;
      elapsed_r <= in_elapsed;
    end
    if (cmd.mul) begin
      prod_r <= delta_r * lag_r;
    end
    cap_r <= {1'b0, cap_prod[CAP_SHIFT +: COUNT_WIDTH-1]};
  end

  // rounded rate term through the divider
  assign div_num = DIV_NUM_W'({prod_r, 1'b0}) + DIV_NUM_W'(elapsed_r);
  assign div_den = {elapsed_r, 1'b0};

  fdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // early-stop amount, capped, only above the small-target threshold
  assign rate      = (elapsed_r != '0) ? div_quo : '0;
  assign early_sum = EARLY_W'(rate) + EARLY_W'(extra_r);
  assign early_c   = (early_sum > EARLY_W'(cap_r)) ? cap_r : early_sum[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (div_done) begin
      early_r <= (target_r > COUNT_WIDTH'(small_r)) ? early_c : '0;
    end
  end

  // sample arithmetic from the current state
  assign run_sum   = (COUNT_WIDTH+1)'(run_r) + (COUNT_WIDTH+1)'(delta_r);
  assign run_s     = run_sum[COUNT_WIDTH] ? COUNT_MAX : run_sum[COUNT_WIDTH-1:0];
  assign quiet_sum = (QUIET_W+1)'(quiet_r) + (QUIET_W+1)'(elapsed_r);
  assign quiet_s   = (delta_r != '0) ? '0 :
                     (quiet_sum[QUIET_W] ? '1 : quiet_sum[QUIET_W-1:0]);
  assign over_lim  = (COUNT_WIDTH+1)'(target_r) + (COUNT_WIDTH+1)'(over_r);
  assign stop_at   = (early_r < target_r) ? target_r - early_r : target_r;
  assign tgt_sat   = (TGT_CMP_W'(tgt_r) > TGT_CMP_W'(COUNT_MAX)) ? COUNT_MAX :
                     COUNT_WIDTH'(tgt_r);

  // saturating grand total
  assign total_src = (op_r == OP_SAMPLE) ? run_s : run_r;
  assign total_sum = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(total_src);
  assign total_s   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // command effect on the run state
  always_comb begin
    mode_nxt   = mode_r;
    run_nxt    = run_r;
    target_nxt = target_r;
    quiet_nxt  = quiet_r;
    fault_nxt  = fault_r;
    stop_nxt   = stop_r;
    total_nxt  = total_r;
    case (op_r)
      OP_START, OP_START_CAL: begin
        if (mode_r == M_IDLE && (op_r == OP_START_CAL || tgt_r != '0)) begin
          run_nxt    = '0;
          quiet_nxt  = '0;
          fault_nxt  = F_NONE;
          target_nxt = (op_r == OP_START) ? tgt_sat : COUNT_WIDTH'(cal_r);
          stop_nxt   = target_nxt;
          mode_nxt   = (op_r == OP_START) ? M_RUN : M_CAL;
        end
      end
      OP_SAMPLE: begin
        if (run_active) begin
          run_nxt   = run_s;
          quiet_nxt = quiet_s;
          if (quiet_s > timeout_r) begin
            mode_nxt  = M_FAULT;
            fault_nxt = F_NO_FLOW;
          end else if (mode_r == M_CAL) begin
            stop_nxt = target_r;
            if (run_s >= target_r) mode_nxt = M_CALDONE;
          end else if ((COUNT_WIDTH+1)'(run_s) > over_lim) begin
            mode_nxt  = M_FAULT;
            fault_nxt = F_OVER;
          end else begin
            stop_nxt = stop_at;
            if (run_s >= stop_at) begin
              mode_nxt  = M_DONE;
              total_nxt = total_s;
            end
          end
        end
      end
      OP_STOP: begin
        if (mode_r == M_RUN) begin
          mode_nxt = M_PAUSE;
        end else if (mode_r == M_CAL) begin
          mode_nxt   = M_IDLE;
          run_nxt    = '0;
          target_nxt = '0;
          quiet_nxt  = '0;
          fault_nxt  = F_NONE;
          stop_nxt   = '0;
        end
      end
      OP_RESUME: begin
        if (mode_r == M_PAUSE) begin
          mode_nxt  = M_RUN;
          quiet_nxt = '0;
        end
      end
      OP_CANCEL, OP_ACK: begin
        if ((op_r == OP_CANCEL && mode_r == M_PAUSE) ||
            (op_r == OP_ACK && (mode_r == M_DONE || mode_r == M_FAULT ||
                                mode_r == M_CALDONE))) begin
          if (op_r == OP_CANCEL) total_nxt = total_s;
          mode_nxt   = M_IDLE;
          run_nxt    = '0;
          target_nxt = '0;
          quiet_nxt  = '0;
          fault_nxt  = F_NONE;
          stop_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  // result word and its valid flag
  always_comb begin
    out_data_nxt                  = out_data_r;
    out_valid_nxt                 = out_valid_r && !out_ready;
    if (cmd.commit) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.run_mode          = mode_nxt;
      out_data_nxt.pump_on           = (mode_nxt == M_RUN) || (mode_nxt == M_CAL);
      out_data_nxt.pulses_dispensed  = run_nxt;
      out_data_nxt.stop_threshold    = stop_nxt;
      out_data_nxt.fault_kind        = fault_nxt;
      out_data_nxt.total_pulses      = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      run_r       <= '0;
      target_r    <= '0;
      quiet_r     <= '0;
      fault_r     <= F_NONE;
      stop_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        mode_r   <= mode_nxt;
        run_r    <= run_nxt;
        target_r <= target_nxt;
        quiet_r  <= quiet_nxt;
        fault_r  <= fault_nxt;
        stop_r   <= stop_nxt;
        total_r  <= total_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/fdc_ctrl.sv]
// ----------------------------------------------------------------------------
// fdc_ctrl - sequencing controller of the dispense controller
// Takes one transaction at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module fdc_ctrl
  import fdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd.latch     = accept;
    cmd.mul       = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = stat.sample_go ? S_MUL : S_COMMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // wait for the result slot to free up
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/flow_batch_dispense_controller_core.sv]
// ----------------------------------------------------------------------------
// flow_batch_dispense_controller_core - batch flow dispense controller
// Runs normal and calibration dispense runs from a command stream.
// ----------------------------------------------------------------------------
// One command per input transaction, one status result per command. A flow
// sample taken while a run is active steps through a multiply state, a load
// state that starts the one-bit-per-cycle divider forming the early-stop
// estimate, a divide state that waits for the divider's done pulse, which
// also registers the estimate, and a commit state that registers its result;
// the next command is taken once the commit is made. Every other command goes
// from acceptance straight to the commit state. The block holds one command at
// a time; a result that is waiting on the output does not stop the next
// command from being accepted, only its commit waits for the output slot.
// Configuration writes take effect at once and are meant to be issued while no
// command is in flight.
module flow_batch_dispense_controller_core
  import fdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // command stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // target_pulses, pulse_delta, elapsed_ms
  input  logic [OP_W-1:0]        in_tuser,   // opcode
  // status stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // run_mode, pump_on, pulses_dispensed,
                                             // stop_threshold, fault_kind, total_pulses
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  out_word_t out_word;

  fdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_target  (in_tdata[TGT_W-1:0]),
    .in_delta   (in_tdata[TGT_W +: DELTA_W]),
    .in_elapsed (in_tdata[TGT_W+DELTA_W +: ELAPSED_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_word)
  );

  assign out_tdata = OUT_TDATA_W'(out_word);

  // one command in flight: acceptance closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // pump drive follows the running modes
  a_pump_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_word.pump_on ==
                    ((out_word.run_mode == M_RUN) || (out_word.run_mode == M_CAL))))
    else $error("pump drive disagrees with run mode");

  // a fault kind is reported exactly in fault mode
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_word.fault_kind != F_NONE) == (out_word.run_mode == M_FAULT)))
    else $error("fault kind disagrees with run mode");

  // idle carries a cleared run
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_word.run_mode == M_IDLE)) |->
      ((out_word.pulses_dispensed == '0) && (out_word.stop_threshold == '0)))
    else $error("idle result with run data left over");

endmodule
